@@ rtl/mmrp_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmrp_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the meter
// response parser.
// -----------------------------------------------------------------------------
package mmrp_pkg;

   typedef logic [4:0] pos_type;

   localparam pos_type POS_FIRST  = 5'd0;
   localparam pos_type POS_CRC_LO = 5'd23;
   localparam pos_type POS_LAST   = 5'd24;
   localparam pos_type POS_IDLE   = 5'd25;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  FUNC_CODE  = 8'h04;
   localparam logic [7:0]  BYTE_COUNT = 8'd20;
   localparam logic [15:0] PF_MAX     = 16'd100;
   localparam logic [7:0]  ADDR_RESET = 8'd1;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_ADDR  = 3'd1,
      ST_FUNC  = 3'd2,
      ST_COUNT = 3'd3,
      ST_CRC   = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] voltage_raw;
      logic [31:0] current_raw;
      logic [31:0] power_raw;
      logic [31:0] energy_wh;
      logic [15:0] frequency_raw;
      logic [6:0]  power_factor_raw;
   } rsp_item_type;

   typedef struct packed {
      logic    valid;
      pos_type byte_position;
   } frame_status_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/mmrp_in.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmrp_in
// Input register: captures one byte transaction per cycle while the pipe moves.
// -----------------------------------------------------------------------------
module mmrp_in (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mmrp_pkg::req_item_type req_item,
   output logic                  item_valid,
   output mmrp_pkg::req_item_type item
);
   import mmrp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   assign req_tready = advance;
   assign valid_in   = advance ? req_tvalid : valid_ff;
   assign item_in    = advance ? req_item : item_ff;
   assign item_valid = valid_ff && advance;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

@@ rtl/mmrp_frame.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmrp_frame
// Frame tracker: byte position, running CRC, header checks and field capture.
// Produces the result for byte 24.
// -----------------------------------------------------------------------------
module mmrp_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  mmrp_pkg::req_item_type    item,
   input  logic [7:0]                expected_address,
   output mmrp_pkg::rsp_item_type    result,
   output mmrp_pkg::frame_status_type frame_status
);
   import mmrp_pkg::*;

   pos_type     pos_ff, pos_in, pos_eff;
   logic [15:0] crc_ff, crc_in, crc_base;
   status_type  err_ff, err_in, err_base, err_final;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] volt_ff, volt_in;
   logic [31:0] curr_ff, curr_in;
   logic [31:0] pwr_ff, pwr_in;
   logic [31:0] nrg_ff, nrg_in;
   logic [15:0] freq_ff, freq_in;
   logic [15:0] pf_ff, pf_in;
   logic        active;
   logic        crc_bad;
   logic [7:0]  b;

   always_comb begin
      b        = item.rx_byte;
      pos_eff  = item.frame_start ? POS_FIRST : pos_ff;
      crc_base = item.frame_start ? CRC_INIT : crc_ff;
      err_base = item.frame_start ? ST_OK : err_ff;
      active   = item_valid && (pos_eff < POS_IDLE);
      crc_bad  = (crc_lo_ff != crc_base[7:0]) || (b != crc_base[15:8]);
      err_final = (err_base == ST_OK && crc_bad) ? ST_CRC : err_base;

      pos_in    = pos_ff;
      crc_in    = crc_ff;
      err_in    = err_ff;
      crc_lo_in = crc_lo_ff;
      volt_in   = volt_ff;
      curr_in   = curr_ff;
      pwr_in    = pwr_ff;
      nrg_in    = nrg_ff;
      freq_in   = freq_ff;
      pf_in     = pf_ff;

      if (active) begin
         pos_in = pos_eff + 5'd1;
         crc_in = (pos_eff < POS_CRC_LO) ? crc_feed(crc_base, b) : crc_base;
         err_in = err_base;
         unique case (pos_eff)
            5'd0: begin
               if (b != expected_address && err_base == ST_OK) err_in = ST_ADDR;
            end
            5'd1: begin
               if (b != FUNC_CODE && err_base == ST_OK) err_in = ST_FUNC;
            end
            5'd2: begin
               if (b != BYTE_COUNT && err_base == ST_OK) err_in = ST_COUNT;
            end
            5'd3:  volt_in[15:8]  = b;
            5'd4:  volt_in[7:0]   = b;
            5'd5:  curr_in[15:8]  = b;
            5'd6:  curr_in[7:0]   = b;
            5'd7:  curr_in[31:24] = b;
            5'd8:  curr_in[23:16] = b;
            5'd9:  pwr_in[15:8]   = b;
            5'd10: pwr_in[7:0]    = b;
            5'd11: pwr_in[31:24]  = b;
            5'd12: pwr_in[23:16]  = b;
            5'd13: nrg_in[15:8]   = b;
            5'd14: nrg_in[7:0]    = b;
            5'd15: nrg_in[31:24]  = b;
            5'd16: nrg_in[23:16]  = b;
            5'd17: freq_in[15:8]  = b;
            5'd18: freq_in[7:0]   = b;
            5'd19: pf_in[15:8]    = b;
            5'd20: pf_in[7:0]     = b;
            5'd23: crc_lo_in      = b;
            5'd24: err_in         = err_final;
            default: ;
         endcase
      end
   end

   always_comb begin
      frame_status.valid         = active && (pos_eff == POS_LAST);
      frame_status.byte_position = pos_ff;
      result.status = err_final;
      if (err_final == ST_OK) begin
         result.voltage_raw      = volt_ff;
         result.current_raw      = curr_ff;
         result.power_raw        = pwr_ff;
         result.energy_wh        = nrg_ff;
         result.frequency_raw    = freq_ff;
         result.power_factor_raw = (pf_ff > PF_MAX) ? PF_MAX[6:0] : pf_ff[6:0];
      end else begin
         result.voltage_raw      = '0;
         result.current_raw      = '0;
         result.power_raw        = '0;
         result.energy_wh        = '0;
         result.frequency_raw    = '0;
         result.power_factor_raw = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_IDLE;
         crc_ff <= CRC_INIT;
         err_ff <= ST_OK;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_lo_ff <= crc_lo_in;
      volt_ff   <= volt_in;
      curr_ff   <= curr_in;
      pwr_ff    <= pwr_in;
      nrg_ff    <= nrg_in;
      freq_ff   <= freq_in;
      pf_ff     <= pf_in;
   end

endmodule

@@ rtl/mmrp_out.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mmrp_out
// Result register: holds one result transaction until the receiver takes it.
// -----------------------------------------------------------------------------
module mmrp_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   input  mmrp_pkg::rsp_item_type load_item,
   output logic                   advance,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output mmrp_pkg::rsp_item_type rsp_item
);
   import mmrp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign advance    = !valid_ff || rsp_tready;
   assign valid_in   = advance ? load_valid : valid_ff;
   assign item_in    = advance ? load_item : item_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

@@ rtl/modbus_meter_response_parser_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// modbus_meter_response_parser_unit
// Parses a 25-byte read-input-registers response from an energy meter.
//
// req_ carries one received byte per transaction; req_tuser flags byte 0 of a
// frame. Bytes outside an open frame are dropped. On byte 24 one rsp_
// transaction is produced: status in rsp_tuser, meter fields in rsp_tdata,
// all data fields zero when the status is not ok.
// The result of byte 24 is registered in the result register after the byte
// passes the input register. Throughput: one byte per cycle unless the receiver
// stalls; the CRC update and field capture are done in a single stage between
// the input and result registers. When the receiver stalls with a result
// pending, req_tready drops and the whole pipe holds; nothing is lost.
// Reset: no frame open, expected address 1, both registers empty.
// csr_wr_en writes csr_wr_data into the expected slave address; write only
// while no transaction is in flight.
// -----------------------------------------------------------------------------
module modbus_meter_response_parser_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  logic         req_tuser,   // [0] frame_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // [15:0] voltage_raw, [47:16] current_raw,
                                     // [79:48] power_raw, [111:80] energy_wh,
                                     // [127:112] frequency_raw,
                                     // [134:128] power_factor_raw, [135] zero
   output logic [2:0]   rsp_tuser,   // [2:0] status
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);
   import mmrp_pkg::*;

   logic             advance;
   logic             item_valid;
   req_item_type     req_item, item;
   rsp_item_type     result, rsp_item;
   frame_status_type frame_status;
   logic [7:0]       addr_ff, addr_in;

   assign addr_in = csr_wr_en ? csr_wr_data : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_RESET;
      end else begin
         addr_ff <= addr_in;
      end
   end

   assign req_item.rx_byte     = req_tdata;
   assign req_item.frame_start = req_tuser;

   mmrp_in u_in (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item)
   );

   mmrp_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .expected_address (addr_ff),
      .result           (result),
      .frame_status     (frame_status)
   );

   mmrp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (frame_status.valid),
      .load_item  (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tuser = rsp_item.status;
   assign rsp_tdata = {1'b0,
                       rsp_item.power_factor_raw,
                       rsp_item.frequency_raw,
                       rsp_item.energy_wh,
                       rsp_item.power_raw,
                       rsp_item.current_raw,
                       rsp_item.voltage_raw};

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("failed frame carries nonzero data");

   a_pf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[134:128] <= 7'd100))
      else $error("power factor above saturation limit");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a pending result");

   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.frame_start) |=> (frame_status.byte_position == 5'd1))
      else $error("frame start did not restart byte position");

   a_result_last: assert property (@(posedge clock) disable iff (reset)
      frame_status.valid |=> (frame_status.byte_position == POS_IDLE))
      else $error("result not on last frame byte");

endmodule

@@ dv/modbus_meter_response_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// modbus_meter_response_parser_unit_tb
// Streams 25-byte meter response frames, clean and damaged, into the parser
// with random gaps and result stalls. A byte-level frame decoder in the bench
// (CRC, header checks, field capture) predicts each status and field set, and
// every result transaction is compared field by field in arrival order.
// -----------------------------------------------------------------------------
module modbus_meter_response_parser_unit_tb;
   import mmrp_pkg::*;

   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 4;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] rx_byte
   logic         req_tuser;   // [0] frame_start
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;   // voltage, current, power, energy, frequency, pf, zero
   logic [2:0]   rsp_tuser;   // [2:0] status
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;

   modbus_meter_response_parser_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // decoder state
   logic [7:0]   meter_addr;
   pos_type      rx_pos;
   logic [15:0]  rx_crc;
   status_type   rx_status;
   logic [7:0]   rx_bytes [0:24];

   rsp_item_type expected_readings [$];
   logic [7:0]   tx_frame [0:24];

   int  mismatch_count;
   int  frame_bytes_taken;
   int  readings_due;
   bit  gaps_on;
   bit  long_hold_req;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [15:0] crc16_bit_serial(logic [15:0] crc, logic [7:0] d);
      logic [15:0] s;
      s = crc;
      for (int i = 0; i < 8; i++) begin
         s = (s[0] ^ d[i]) ? ((s >> 1) ^ CRC_POLY) : (s >> 1);
      end
      return s;
   endfunction

   function automatic void decode_rx_byte(logic [7:0] b, logic start);
      rsp_item_type r;
      logic [15:0]  pf;
      if (start) begin
         rx_pos    = POS_FIRST;
         rx_crc    = CRC_INIT;
         rx_status = ST_OK;
      end
      if (rx_pos >= POS_IDLE) return;
      frame_bytes_taken++;
      rx_bytes[rx_pos] = b;
      if (rx_pos < POS_CRC_LO) rx_crc = crc16_bit_serial(rx_crc, b);
      if (rx_pos == POS_FIRST && b != meter_addr && rx_status == ST_OK) rx_status = ST_ADDR;
      if (rx_pos == 5'd1 && b != FUNC_CODE && rx_status == ST_OK) rx_status = ST_FUNC;
      if (rx_pos == 5'd2 && b != BYTE_COUNT && rx_status == ST_OK) rx_status = ST_COUNT;
      if (rx_pos == POS_LAST) begin
         if (rx_status == ST_OK && {b, rx_bytes[POS_CRC_LO]} != rx_crc) rx_status = ST_CRC;
         pf = {rx_bytes[19], rx_bytes[20]};
         r.status           = rx_status;
         r.voltage_raw      = {rx_bytes[3], rx_bytes[4]};
         r.current_raw      = {rx_bytes[7], rx_bytes[8], rx_bytes[5], rx_bytes[6]};
         r.power_raw        = {rx_bytes[11], rx_bytes[12], rx_bytes[9], rx_bytes[10]};
         r.energy_wh        = {rx_bytes[15], rx_bytes[16], rx_bytes[13], rx_bytes[14]};
         r.frequency_raw    = {rx_bytes[17], rx_bytes[18]};
         r.power_factor_raw = (pf > PF_MAX) ? PF_MAX[6:0] : pf[6:0];
         if (rx_status != ST_OK) begin
            r = '0;
            r.status = rx_status;
         end
         expected_readings.push_back(r);
         readings_due++;
      end
      rx_pos = rx_pos + 5'd1;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch %s: expected %0h actual %0h", $realtime, what, want, got);
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            note_mismatch("unexpected transaction status", 32'd0, 32'(rsp_tuser));
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tuser != want.status)
               note_mismatch("status", 32'(want.status), 32'(rsp_tuser));
            if (rsp_tdata[15:0] != want.voltage_raw)
               note_mismatch("voltage_raw", 32'(want.voltage_raw), 32'(rsp_tdata[15:0]));
            if (rsp_tdata[47:16] != want.current_raw)
               note_mismatch("current_raw", want.current_raw, rsp_tdata[47:16]);
            if (rsp_tdata[79:48] != want.power_raw)
               note_mismatch("power_raw", want.power_raw, rsp_tdata[79:48]);
            if (rsp_tdata[111:80] != want.energy_wh)
               note_mismatch("energy_wh", want.energy_wh, rsp_tdata[111:80]);
            if (rsp_tdata[127:112] != want.frequency_raw)
               note_mismatch("frequency_raw", 32'(want.frequency_raw),
                             32'(rsp_tdata[127:112]));
            if (rsp_tdata[135:128] != {1'b0, want.power_factor_raw})
               note_mismatch("power_factor_raw", 32'(want.power_factor_raw),
                             32'(rsp_tdata[135:128]));
         end
      end
   end

   // result receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_rx_byte(b, start);
   endtask

   task automatic send_frame(input int first, input int last);
      for (int i = first; i <= last; i++) send_byte(tx_frame[i], i == 0);
   endtask

   task automatic seal_frame();
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < POS_CRC_LO; i++) c = crc16_bit_serial(c, tx_frame[i]);
      tx_frame[23] = c[7:0];
      tx_frame[24] = c[15:8];
   endtask

   task automatic make_frame(input logic [7:0] a, input logic [7:0] fn, input logic [7:0] cnt);
      tx_frame[0] = a;
      tx_frame[1] = fn;
      tx_frame[2] = cnt;
      for (int i = 3; i < POS_CRC_LO; i++) tx_frame[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) begin
         tx_frame[19] = 8'h00;
         tx_frame[20] = 8'($urandom_range(90, 110));
      end
      seal_frame();
   endtask

   // register write only once the pipe has drained
   task automatic write_address(input logic [7:0] a);
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= a;
      @(posedge clock);
      meter_addr = a;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_good_frames();
      make_frame(meter_addr, FUNC_CODE, BYTE_COUNT);
      for (int i = 3; i < POS_CRC_LO; i++) tx_frame[i] = 8'h00;
      tx_frame[20] = 8'd100;
      seal_frame();
      send_frame(0, 24);
      for (int i = 3; i < POS_CRC_LO; i++) tx_frame[i] = 8'hFF;
      seal_frame();
      send_frame(0, 24);
      make_frame(meter_addr, FUNC_CODE, BYTE_COUNT);
      tx_frame[19] = 8'h00;
      tx_frame[20] = 8'd101;
      seal_frame();
      send_frame(0, 24);
   endtask

   task automatic test_header_errors();
      make_frame(meter_addr ^ 8'h80, 8'h03, BYTE_COUNT);
      send_frame(0, 24);
      make_frame(meter_addr, 8'h84, 8'd19);
      send_frame(0, 24);
      make_frame(meter_addr, FUNC_CODE, 8'hFF);
      send_frame(0, 24);
      make_frame(meter_addr, FUNC_CODE, BYTE_COUNT);
      tx_frame[24] = tx_frame[24] ^ 8'h01;
      send_frame(0, 24);
      make_frame(meter_addr ^ 8'h01, FUNC_CODE, BYTE_COUNT);
      tx_frame[23] = ~tx_frame[23];
      send_frame(0, 24);
   endtask

   task automatic test_framing();
      for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      make_frame(meter_addr, FUNC_CODE, BYTE_COUNT);
      send_frame(0, 9);
      make_frame(meter_addr, FUNC_CODE, BYTE_COUNT);
      send_frame(0, 23);
      send_frame(0, 24);
      for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic test_address_register();
      write_address(8'h00);
      make_frame(8'h00, FUNC_CODE, BYTE_COUNT);
      send_frame(0, 24);
      write_address(8'hFF);
      make_frame(8'hFF, FUNC_CODE, BYTE_COUNT);
      send_frame(0, 24);
      make_frame(ADDR_RESET, FUNC_CODE, BYTE_COUNT);
      send_frame(0, 24);
      // address is judged at byte 0; a later write does not affect this frame
      make_frame(8'hFF, FUNC_CODE, BYTE_COUNT);
      send_frame(0, 0);
      write_address(8'h5A);
      send_frame(1, 24);
      write_address(ADDR_RESET);
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      long_hold_req = 1'b1;
      for (int f = 0; f < 4; f++) begin
         make_frame(meter_addr, FUNC_CODE, BYTE_COUNT);
         send_frame(0, 24);
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int kind;
      int n;
      frame_bytes_taken = 0;
      readings_due = 0;
      while (frame_bytes_taken < 480 || readings_due < 15) begin
         if (frame_bytes_taken > 400) gaps_on = 1'b0;
         if ($urandom_range(0, 24) == 0) begin
            case ($urandom_range(0, 3))
               0:       write_address(8'h00);
               1:       write_address(8'hFF);
               default: write_address(8'($urandom_range(0, 255)));
            endcase
         end
         kind = $urandom_range(0, 99);
         make_frame(meter_addr, FUNC_CODE, BYTE_COUNT);
         if (kind >= 58 && kind < 64) begin
            tx_frame[0] = meter_addr ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1)) seal_frame();
         end else if (kind >= 64 && kind < 70) begin
            tx_frame[1] = FUNC_CODE ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1)) tx_frame[2] = 8'($urandom_range(0, 255));
            seal_frame();
         end else if (kind >= 70 && kind < 76) begin
            tx_frame[2] = BYTE_COUNT ^ 8'($urandom_range(1, 255));
            seal_frame();
         end else if (kind >= 76 && kind < 84) begin
            n = $urandom_range(3, 24);
            tx_frame[n] = tx_frame[n] ^ (8'h01 << $urandom_range(0, 7));
         end
         if (kind >= 84 && kind < 90) begin
            send_frame(0, $urandom_range(0, 23));
         end else if (kind >= 90 && kind < 96) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_frame(0, 24);
            if (kind >= 96) begin
               n = $urandom_range(1, 6);
               for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         end
      end
   endtask

   initial begin
      int waited;
      mismatch_count = 0;
      gaps_on        = 1'b1;
      long_hold_req  = 1'b0;
      meter_addr     = ADDR_RESET;
      rx_pos         = POS_IDLE;
      rx_crc         = CRC_INIT;
      rx_status      = ST_OK;
      for (int i = 0; i <= POS_LAST; i++) rx_bytes[i] = 8'h00;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 8'h00;
      req_tuser   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_good_frames();
      test_header_errors();
      test_framing();
      test_address_register();
      test_backpressure();
      test_random_traffic();

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_readings.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ modbus_meter_response_parser_unit.f @@
rtl/mmrp_pkg.sv
rtl/mmrp_in.sv
rtl/mmrp_frame.sv
rtl/mmrp_out.sv
rtl/modbus_meter_response_parser_unit.sv
dv/modbus_meter_response_parser_unit_tb.sv
